[hdl/ghra_pkg.sv]
package ghra_pkg;

  localparam int GuestRegs  = 32;
  localparam int HostRegs   = 16;
  localparam int GW         = $clog2(GuestRegs);
  localparam int HW         = $clog2(HostRegs);
  localparam int CW         = $clog2(HostRegs + 1);
  localparam int MaxResults = HostRegs + 2;
  localparam int RCW        = $clog2(MaxResults + 1);
  localparam logic [15:0] MaskReset = 16'hF00F;

  typedef enum logic [2:0] {
    CMD_REBUILD = 3'd0,
    CMD_MAP     = 3'd1,
    CMD_DIRTY   = 3'd2,
    CMD_UNLOCK  = 3'd3,
    CMD_FLUSH   = 3'd4,
    CMD_WRBACK  = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    OP_STORE  = 3'd0,
    OP_LOAD   = 3'd1,
    OP_ZERO   = 3'd2,
    OP_DONE   = 3'd3,
    OP_NOFREE = 3'd4
  } op_e;

  localparam logic [1:0] ActLoad   = 2'd1;
  localparam logic [1:0] ActBranch = 2'd2;
  localparam logic [3:0] KindEmpty = 4'd0;
  localparam logic [3:0] KindRsvd  = 4'd1;

  typedef struct packed {
    logic [2:0] command;
    logic [4:0] guest_reg;
    logic [3:0] host_reg;
    logic [1:0] load_action;
    logic [3:0] reg_kind;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op_kind;
    logic [3:0] host_index;
    logic [4:0] guest_index;
    logic       last;
  } res_t;

endpackage

[hdl/guest_host_register_allocator.sv]
// channel | dir | tdata (low bit first)                            | tuser        | tlast
// s_axis  | in  | guest_reg[4:0] host_reg[8:5] load_action[10:9]    | command[2:0] |
//         |     | reg_kind[14:11], zero pad to 16                  |              |
// m_axis  | out | host_index[3:0] guest_index[8:4], zero pad to 16 | op_kind[2:0] | last
// cfg     | in  | reserved_host_mask[15:0] on cfg_wdata_i          |              |
// a map's pointer scan and spill each walk the free order
// flush and write back walk all 32 guest entries, rebuild walks all 16 host entries
// dirty, unlock and unknown commands are answered straight from the idle state
// after reset the back end builds the pool over all 16 host entries; the queue takes two transfers
// a stalled output freezes the back end, then the two-entry queue fills and drops tready
module guest_host_register_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // guest_reg, host_reg, load_action, reg_kind
  input  logic [2:0]  s_axis_tuser_i,   // command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // host_index, guest_index
  output logic [2:0]  m_axis_tuser_o,   // op_kind
  output logic        m_axis_tlast_o
);
  import ghra_pkg::*;

  logic [15:0] mask_q;
  logic q_valid, q_ready;
  cmd_t q_cmd;
  res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= MaskReset;
    end else if (cfg_we_i) begin
      mask_q <= cfg_wdata_i;
    end
  end

  ghra_front u_front (
    .clk_i,
    .rst_ni,
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_cmd_o    (q_cmd)
  );

  ghra_back u_back (
    .clk_i,
    .rst_ni,
    .mask_i    (mask_q),
    .q_valid_i (q_valid),
    .q_ready_o (q_ready),
    .q_cmd_i   (q_cmd),
    .r_valid_o (m_axis_tvalid_o),
    .r_ready_i (m_axis_tready_i),
    .r_data_o  (res)
  );

  assign m_axis_tdata_o = {7'd0, res.guest_index, res.host_index};
  assign m_axis_tuser_o = res.op_kind;
  assign m_axis_tlast_o = res.last;

`ifndef ASSERT_OFF
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped under stall");
  a_stall_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("result changed under stall");
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      m_axis_tlast_o == (m_axis_tuser_o == OP_DONE || m_axis_tuser_o == OP_NOFREE))
    else $error("tlast does not match op kind");
`endif
endmodule

[hdl/ghra_front.sv]
module ghra_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_tvalid_i,
  output logic            s_tready_o,
  input  logic [15:0]     s_tdata_i,   // guest_reg, host_reg, load_action, reg_kind
  input  logic [2:0]      s_tuser_i,   // command
  output logic            q_valid_o,
  input  logic            q_ready_i,
  output ghra_pkg::cmd_t  q_cmd_o
);
  import ghra_pkg::*;

  cmd_t q0_q, q1_q;
  logic [1:0] cnt_q, cnt_d;
  cmd_t in_cmd;
  logic push, pop;
  logic unused_pad;

  assign in_cmd.command     = s_tuser_i;
  assign in_cmd.guest_reg   = s_tdata_i[4:0];
  assign in_cmd.host_reg    = s_tdata_i[8:5];
  assign in_cmd.load_action = s_tdata_i[10:9];
  assign in_cmd.reg_kind    = s_tdata_i[14:11];
  assign unused_pad = s_tdata_i[15];

  assign s_tready_o = cnt_q != 2'd2;
  assign push = s_tvalid_i && s_tready_o;
  assign q_valid_o = cnt_q != 2'd0;
  assign pop = q_valid_o && q_ready_i;
  assign q_cmd_o = q0_q;

  always_comb begin
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      q0_q <= (cnt_q == 2'd2) ? q1_q : in_cmd;
    end else if (push && cnt_q == 2'd0) begin
      q0_q <= in_cmd;
    end
    if (push && (cnt_q == 2'd1 && !pop || cnt_q == 2'd2)) begin
      q1_q <= in_cmd;
    end
  end
endmodule

[hdl/ghra_back.sv]
module ghra_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [15:0]     mask_i,
  input  logic            q_valid_i,
  output logic            q_ready_o,
  input  ghra_pkg::cmd_t  q_cmd_i,
  output logic            r_valid_o,
  input  logic            r_ready_i,
  output ghra_pkg::res_t  r_data_o
);
  import ghra_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_BUILD = 6'b000010,
    ST_SCAN  = 6'b000100,
    ST_SPILL = 6'b001000,
    ST_ALLOC = 6'b010000,
    ST_GLOOP = 6'b100000
  } st_e;

  st_e st_q;
  cmd_t c_q;
  logic [GuestRegs-1:0] gmap_q, gdirty_q;
  logic [HW-1:0] g2h_q [GuestRegs];
  logic [3:0] hkind_q [HostRegs];
  logic [HostRegs-1:0] hlock_q, hmapd_q, hhold_q;
  logic [GW-1:0] h2g_q [HostRegs];
  logic [HW-1:0] ford_q [HostRegs];
  logic [CW-1:0] fcnt_q, ptr_q, idx_q;
  logic [GW:0] gi_q;
  logic found_q;
  logic boot_q;
  logic [RCW-1:0] n_q;
  logic out_vld_q;
  res_t out_dat_q;

  logic emv_q;
  res_t emd_q;
  logic busy;
  assign busy = r_valid_o && !r_ready_i;
  assign q_ready_o = st_q == ST_IDLE && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!busy) begin
      out_vld_q <= emv_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (!busy) out_dat_q <= emd_q;
  end
  assign r_valid_o = out_vld_q;
  assign r_data_o = out_dat_q;

  function automatic res_t mk(op_e op, logic [3:0] h, logic [4:0] g, logic l);
    res_t r;
    r.op_kind = op;
    r.host_index = h;
    r.guest_index = g;
    r.last = l;
    return r;
  endfunction

  logic [HW-1:0] hcur;
  logic [GW-1:0] gcur;
  logic [GW-1:0] gi;
  logic [HW-1:0] hsel;
  assign hcur = ford_q[idx_q[HW-1:0]];
  assign gcur = h2g_q[hcur];
  assign gi = gi_q[GW-1:0];
  assign hsel = g2h_q[c_q.guest_reg];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_BUILD;
      ptr_q <= '0;
      idx_q <= '0;
      fcnt_q <= '0;
      gi_q <= '0;
      n_q <= '0;
      found_q <= 1'b0;
      boot_q <= 1'b1;
      emv_q <= 1'b0;
      c_q <= '0;
      gmap_q <= '0;
      gdirty_q <= '0;
      hlock_q <= '0;
      hmapd_q <= '0;
      hhold_q <= '0;
    end else if (!busy) begin
      emv_q <= 1'b0;
      unique case (st_q)
        ST_IDLE: begin
          n_q <= '0;
          if (q_valid_i) begin
            c_q <= q_cmd_i;
            idx_q <= '0;
            unique case (q_cmd_i.command)
              CMD_REBUILD: begin
                st_q <= ST_BUILD;
                fcnt_q <= '0;
              end
              CMD_MAP: st_q <= ST_SCAN;
              CMD_DIRTY: begin
                gdirty_q[q_cmd_i.guest_reg] <= 1'b1;
                emv_q <= 1'b1;
                emd_q <= mk(OP_DONE, 4'd0, 5'd0, 1'b1);
              end
              CMD_UNLOCK: begin
                hlock_q[q_cmd_i.host_reg] <= 1'b0;
                emv_q <= 1'b1;
                emd_q <= mk(OP_DONE, q_cmd_i.host_reg, 5'd0, 1'b1);
              end
              CMD_FLUSH: begin
                gi_q <= '0;
                st_q <= ST_GLOOP;
              end
              CMD_WRBACK: begin
                gi_q <= '0;
                st_q <= ST_GLOOP;
              end
              default: begin
                emv_q <= 1'b1;
                emd_q <= mk(OP_DONE, 4'd0, 5'd0, 1'b1);
              end
            endcase
          end
        end
        ST_BUILD: begin
          if (idx_q == '0) begin
            gmap_q <= '0;
            gdirty_q <= '0;
            hlock_q <= '0;
            hmapd_q <= '0;
            hhold_q <= '0;
          end
          hkind_q[idx_q[HW-1:0]] <= mask_i[idx_q[HW-1:0]] ? KindRsvd : KindEmpty;
          h2g_q[idx_q[HW-1:0]] <= '0;
          if (!mask_i[idx_q[HW-1:0]]) begin
            ford_q[(idx_q == '0) ? '0 : fcnt_q[HW-1:0]] <= idx_q[HW-1:0];
            fcnt_q <= ((idx_q == '0) ? CW'(0) : fcnt_q) + CW'(1);
          end else if (idx_q == '0) begin
            fcnt_q <= '0;
          end
          if (idx_q == CW'(HostRegs - 1)) begin
            st_q <= ST_IDLE;
            boot_q <= 1'b0;
            if (!boot_q) begin
              emv_q <= 1'b1;
              emd_q <= mk(OP_DONE, 4'd0, 5'd0, 1'b1);
            end
          end else begin
            idx_q <= idx_q + CW'(1);
          end
        end
        ST_SCAN: begin
          if (gmap_q[c_q.guest_reg]) begin
            st_q <= ST_IDLE;
            hlock_q[hsel] <= 1'b1;
            emv_q <= 1'b1;
            emd_q <= mk(OP_DONE, hsel, 5'd0, 1'b1);
            if (c_q.load_action == ActBranch) begin
              if (c_q.guest_reg != '0 && gdirty_q[c_q.guest_reg]) begin
                emv_q <= 1'b1;
                emd_q <= mk(OP_STORE, hsel, c_q.guest_reg, 1'b0);
                st_q <= ST_ALLOC;
                found_q <= 1'b1;
              end else begin
                g2h_q[c_q.guest_reg] <= '0;
              end
              gdirty_q[c_q.guest_reg] <= 1'b0;
              gmap_q[c_q.guest_reg] <= 1'b0;
              hkind_q[hsel] <= c_q.reg_kind;
              hhold_q[hsel] <= 1'b1;
              hmapd_q[hsel] <= 1'b0;
              h2g_q[hsel] <= '0;
            end
          end else if (ptr_q < fcnt_q && hkind_q[ford_q[ptr_q[HW-1:0]]] != KindEmpty) begin
            ptr_q <= ptr_q + CW'(1);
          end else if (ptr_q < fcnt_q) begin
            found_q <= 1'b0;
            st_q <= ST_ALLOC;
          end else begin
            idx_q <= '0;
            found_q <= 1'b0;
            st_q <= ST_SPILL;
          end
        end
        ST_SPILL: begin
          if (idx_q >= fcnt_q) begin
            if (!found_q) begin
              st_q <= ST_IDLE;
              emv_q <= 1'b1;
              emd_q <= mk(OP_NOFREE, 4'd0, 5'd0, 1'b1);
            end else begin
              st_q <= ST_ALLOC;
              found_q <= 1'b0;
              idx_q <= '0;
            end
          end else begin
            idx_q <= idx_q + CW'(1);
            if (!hlock_q[hcur]) begin
              if (gcur != '0 && gdirty_q[gcur] && n_q < RCW'(MaxResults - 1)) begin
                emv_q <= 1'b1;
                emd_q <= mk(OP_STORE, hcur, gcur, 1'b0);
                n_q <= n_q + RCW'(1);
              end
              gdirty_q[gcur] <= 1'b0;
              gmap_q[gcur] <= 1'b0;
              g2h_q[gcur] <= '0;
              hkind_q[hcur] <= KindEmpty;
              hmapd_q[hcur] <= 1'b0;
              h2g_q[hcur] <= '0;
              hhold_q[hcur] <= 1'b0;
              if (!found_q) begin
                ptr_q <= idx_q;
                found_q <= 1'b1;
              end
            end
          end
        end
        ST_ALLOC: begin
          if (found_q) begin
            // branch load of a mapped guest, done after its store
            st_q <= ST_IDLE;
            found_q <= 1'b0;
            g2h_q[c_q.guest_reg] <= '0;
            emv_q <= 1'b1;
            emd_q <= mk(OP_DONE, hsel, 5'd0, 1'b1);
          end else if (idx_q == CW'(HostRegs)) begin
            st_q <= ST_IDLE;
            emv_q <= 1'b1;
            emd_q <= mk(OP_DONE, ford_q[ptr_q[HW-1:0] - HW'(1)], 5'd0, 1'b1);
          end else begin
            hkind_q[ford_q[ptr_q[HW-1:0]]] <= c_q.reg_kind;
            hlock_q[ford_q[ptr_q[HW-1:0]]] <= 1'b1;
            gdirty_q[c_q.guest_reg] <= 1'b0;
            if (c_q.load_action != ActBranch) begin
              hhold_q[ford_q[ptr_q[HW-1:0]]] <= 1'b0;
              hmapd_q[ford_q[ptr_q[HW-1:0]]] <= 1'b1;
              h2g_q[ford_q[ptr_q[HW-1:0]]] <= c_q.guest_reg;
              gmap_q[c_q.guest_reg] <= 1'b1;
              g2h_q[c_q.guest_reg] <= ford_q[ptr_q[HW-1:0]];
            end else begin
              hhold_q[ford_q[ptr_q[HW-1:0]]] <= 1'b1;
              hmapd_q[ford_q[ptr_q[HW-1:0]]] <= 1'b0;
              h2g_q[ford_q[ptr_q[HW-1:0]]] <= '0;
            end
            if (c_q.load_action == ActLoad || c_q.load_action == ActBranch) begin
              emv_q <= 1'b1;
              emd_q <= (c_q.guest_reg != '0) ?
                       mk(OP_LOAD, ford_q[ptr_q[HW-1:0]], c_q.guest_reg, 1'b0) :
                       mk(OP_ZERO, ford_q[ptr_q[HW-1:0]], 5'd0, 1'b0);
            end
            ptr_q <= ptr_q + CW'(1);
            idx_q <= CW'(HostRegs);
          end
        end
        ST_GLOOP: begin
          if (gi_q == (GW+1)'(GuestRegs)) begin
            st_q <= ST_IDLE;
            emv_q <= 1'b1;
            emd_q <= mk(OP_DONE, 4'd0, 5'd0, 1'b1);
          end else begin
            gi_q <= gi_q + (GW+1)'(1);
            if (gmap_q[gi]) begin
              if (gi != '0 && gdirty_q[gi] && n_q < RCW'(MaxResults - 1)) begin
                emv_q <= 1'b1;
                emd_q <= mk(OP_STORE, g2h_q[gi], gi, 1'b0);
                n_q <= n_q + RCW'(1);
              end
              if (c_q.command == CMD_FLUSH) begin
                gdirty_q[gi] <= 1'b0;
                gmap_q[gi] <= 1'b0;
                g2h_q[gi] <= '0;
                hkind_q[g2h_q[gi]] <= KindEmpty;
                hlock_q[g2h_q[gi]] <= 1'b0;
                hmapd_q[g2h_q[gi]] <= 1'b0;
                h2g_q[g2h_q[gi]] <= '0;
                hhold_q[g2h_q[gi]] <= 1'b0;
              end
            end
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  logic unused;
  assign unused = ^{hmapd_q, hhold_q};
endmodule

[tb/sv/tb_guest_host_register_allocator.sv]
`timescale 1ns / 100ps

module tb_guest_host_register_allocator;
  import ghra_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;  // guest_reg, host_reg, load_action, reg_kind
  logic [2:0]  s_axis_tuser_i = '0;  // command
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;       // host_index, guest_index
  logic [2:0]  m_axis_tuser_o;       // op_kind
  logic        m_axis_tlast_o;

  guest_host_register_allocator u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  localparam int WatchdogLimit = 3000;
  localparam int DrainCycles   = 60;

  // allocator mirror
  logic [15:0] mask_q;
  bit          gst_mapped[GuestRegs];
  bit          gst_dirty[GuestRegs];
  logic [3:0]  gst_host[GuestRegs];
  logic [3:0]  hst_kind[HostRegs];
  bit          hst_locked[HostRegs];
  bit          hst_mapped[HostRegs];
  logic [4:0]  hst_guest[HostRegs];
  bit          hst_hold[HostRegs];
  logic [3:0]  free_order[HostRegs];
  int          free_cnt;
  int          alloc_ptr;
  res_t        cmd_results[$];
  res_t        pending_ops[$];

  int  errors = 0;
  int  idle_cycles = 0;
  bit  tx_burst = 1'b0;
  bit  rx_burst = 1'b0;
  bit  hold_req = 1'b0;
  int  hold_len = 0;

  function automatic void emit(op_e op, int h, int g, bit last);
    if (cmd_results.size() >= MaxResults || (!last && cmd_results.size() >= MaxResults - 1))
      return;
    cmd_results.push_back(res_t'{op, 4'(h), 5'(g), last});
  endfunction

  function automatic void rebuild_pool();
    free_cnt = 0;
    for (int g = 0; g < GuestRegs; g++) begin
      gst_mapped[g] = 0;
      gst_dirty[g]  = 0;
      gst_host[g]   = '0;
    end
    for (int h = 0; h < HostRegs; h++) begin
      hst_locked[h] = 0;
      hst_mapped[h] = 0;
      hst_guest[h]  = '0;
      hst_hold[h]   = 0;
      hst_kind[h]   = mask_q[h] ? KindRsvd : KindEmpty;
      if (!mask_q[h]) begin
        free_order[free_cnt] = 4'(h);
        free_cnt++;
      end
    end
  endfunction

  function automatic void release_host(int h);
    hst_kind[h]   = KindEmpty;
    hst_locked[h] = 0;
    hst_mapped[h] = 0;
    hst_guest[h]  = '0;
    hst_hold[h]   = 0;
  endfunction

  function automatic bit spill_unlocked();
    bit found;
    int h;
    int g;
    found = 0;
    for (int i = 0; i < free_cnt; i++) begin
      h = free_order[i];
      if (hst_locked[h]) continue;
      g = hst_guest[h];
      if (g != 0 && gst_dirty[g]) emit(OP_STORE, h, g, 0);
      gst_dirty[g]  = 0;
      gst_mapped[g] = 0;
      gst_host[g]   = '0;
      release_host(h);
      if (!found) begin
        alloc_ptr = i;
        found = 1;
      end
    end
    return found;
  endfunction

  function automatic void map_guest(int g, logic [1:0] act, logic [3:0] kind);
    int h;
    if (gst_mapped[g]) begin
      h = gst_host[g];
      if (act == ActBranch) begin
        if (g != 0 && gst_dirty[g]) emit(OP_STORE, h, g, 0);
        gst_dirty[g]  = 0;
        gst_mapped[g] = 0;
        gst_host[g]   = '0;
        hst_kind[h]   = kind;
        hst_hold[h]   = 1;
        hst_mapped[h] = 0;
        hst_guest[h]  = '0;
      end
      hst_locked[h] = 1;
      emit(OP_DONE, h, 0, 1);
      return;
    end
    while (alloc_ptr < free_cnt && hst_kind[free_order[alloc_ptr]] != KindEmpty)
      alloc_ptr++;
    if (alloc_ptr >= free_cnt) begin
      if (!spill_unlocked()) begin
        emit(OP_NOFREE, 0, 0, 1);
        return;
      end
    end
    h = free_order[alloc_ptr];
    hst_kind[h]   = kind;
    hst_locked[h] = 1;
    gst_dirty[g]  = 0;
    if (act != ActBranch) begin
      hst_hold[h]   = 0;
      hst_mapped[h] = 1;
      hst_guest[h]  = 5'(g);
      gst_mapped[g] = 1;
      gst_host[g]   = 4'(h);
    end else begin
      hst_hold[h]   = 1;
      hst_mapped[h] = 0;
      hst_guest[h]  = '0;
    end
    if (act == ActLoad || act == ActBranch) begin
      if (g != 0) emit(OP_LOAD, h, g, 0);
      else emit(OP_ZERO, h, 0, 0);
    end
    alloc_ptr++;
    emit(OP_DONE, h, 0, 1);
  endfunction

  function automatic void predict_command(cmd_t c);
    int h;
    cmd_results.delete();
    case (c.command)
      CMD_REBUILD: rebuild_pool();
      CMD_MAP: map_guest(c.guest_reg, c.load_action, c.reg_kind);
      CMD_DIRTY: gst_dirty[c.guest_reg] = 1;
      CMD_UNLOCK: begin
        hst_locked[c.host_reg] = 0;
        emit(OP_DONE, c.host_reg, 0, 1);
      end
      CMD_FLUSH: begin
        for (int g = 0; g < GuestRegs; g++) begin
          if (!gst_mapped[g]) continue;
          h = gst_host[g];
          if (g != 0 && gst_dirty[g]) emit(OP_STORE, h, g, 0);
          gst_dirty[g]  = 0;
          gst_mapped[g] = 0;
          gst_host[g]   = '0;
          release_host(h);
        end
      end
      CMD_WRBACK: begin
        for (int g = 1; g < GuestRegs; g++)
          if (gst_mapped[g] && gst_dirty[g]) emit(OP_STORE, gst_host[g], g, 0);
      end
      default: ;
    endcase
    if (cmd_results.size() == 0 || !cmd_results[$].last) emit(OP_DONE, 0, 0, 1);
    foreach (cmd_results[i]) pending_ops.push_back(cmd_results[i]);
  endfunction

  task automatic send_command(logic [2:0] cmd, int g, int h, int act, int kind);
    cmd_t c;
    int   gap;
    c = cmd_t'{cmd, 5'(g), 4'(h), 2'(act), 4'(kind)};
    gap = tx_burst ? 0 : $urandom_range(7);
    if (gap > 0) begin
      @(negedge clk_i) s_axis_tvalid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, c.reg_kind, c.load_action, c.host_reg, c.guest_reg};
    s_axis_tuser_i  <= c.command;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_command(c);
  endtask

  task automatic wait_quiet();
    @(negedge clk_i) s_axis_tvalid_i <= 1'b0;
    while (pending_ops.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_mask(logic [15:0] m);
    wait_quiet();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(negedge clk_i) cfg_we_i <= 1'b0;
    mask_q = m;
  endtask

  task automatic send_random(int n);
    int sel;
    int g;
    int kind;
    for (int i = 0; i < n; i++) begin
      sel  = $urandom_range(99);
      g    = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(15);
      kind = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(15, 2);
      if (sel < 45)      send_command(CMD_MAP, g, $urandom_range(15), $urandom_range(3), kind);
      else if (sel < 65) send_command(CMD_DIRTY, g, $urandom_range(15), $urandom_range(3), kind);
      else if (sel < 86) send_command(CMD_UNLOCK, $urandom_range(31), $urandom_range(15),
                                      $urandom_range(3), kind);
      else if (sel < 90) send_command(CMD_FLUSH, g, $urandom_range(15), $urandom_range(3), kind);
      else if (sel < 95) send_command(CMD_WRBACK, g, $urandom_range(15), $urandom_range(3), kind);
      else if (sel < 97) send_command(CMD_REBUILD, g, $urandom_range(15), $urandom_range(3), kind);
      else send_command(3'($urandom_range(7, 6)), g, $urandom_range(15), $urandom_range(3), kind);
    end
  endtask

  task automatic test_directed();
    send_command(CMD_MAP, 0, 0, 1, 2);
    send_command(CMD_MAP, 31, 15, 2, 15);
    send_command(CMD_MAP, 5, 0, 3, 0);
    send_command(CMD_DIRTY, 5, 0, 0, 2);
    send_command(CMD_MAP, 5, 0, 2, 7);
    send_command(CMD_DIRTY, 30, 0, 0, 2);
    send_command(CMD_WRBACK, 0, 0, 0, 2);
    send_command(CMD_FLUSH, 0, 0, 0, 2);
    send_command(CMD_UNLOCK, 0, 15, 0, 2);
    send_command(CMD_UNLOCK, 0, 0, 0, 2);
    send_command(3'd6, 31, 15, 3, 15);
    send_command(3'd7, 0, 0, 0, 0);
    send_command(CMD_REBUILD, 0, 0, 0, 2);
    // lock every pool entry, then ask for five more
    for (int g = 1; g <= 13; g++) send_command(CMD_MAP, g, 0, 1, 3);
    for (int g = 1; g <= 6; g++) send_command(CMD_DIRTY, g, 0, 0, 2);
  endtask

  task automatic test_spill();
    for (int h = 0; h < HostRegs; h++) send_command(CMD_UNLOCK, 0, h, 0, 2);
    send_command(CMD_MAP, 20, 0, 1, 4);
    send_command(CMD_MAP, 0, 0, 2, 4);
    send_command(CMD_FLUSH, 0, 0, 0, 2);
  endtask

  task automatic test_mask_settings();
    logic [15:0] masks[5];
    masks = '{16'h0000, 16'hFFFF, 16'h7FFE, 16'hF0F0, 16'h0000};
    masks[4] = 16'($urandom);
    foreach (masks[i]) begin
      write_mask(masks[i]);
      send_command(CMD_REBUILD, 0, 0, 0, 2);
      send_random(24);
    end
    write_mask(MaskReset);
    send_command(CMD_REBUILD, 0, 0, 0, 2);
  endtask

  task automatic test_random();
    for (int p = 0; p < 8; p++) begin
      tx_burst = (p % 4 == 1);
      rx_burst = (p % 4 == 2);
      send_random(30);
    end
    tx_burst = 0;
    rx_burst = 0;
  endtask

  task automatic test_backpressure();
    hold_len = 300;
    hold_req = 1'b1;
    tx_burst = 1'b1;
    send_random(40);
    tx_burst = 1'b0;
  endtask

  // receiver
  initial begin
    int d;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        d = hold_len;
      end else begin
        d = rx_burst ? 0 : $urandom_range(7);
      end
      if (d > 0) begin
        @(negedge clk_i) m_axis_tready_i <= 1'b0;
        repeat (d - 1) @(negedge clk_i);
      end
      @(negedge clk_i) m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid_o && m_axis_tready_i));
    end
  end

  // result checker
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = res_t'{m_axis_tuser_o, m_axis_tdata_o[3:0], m_axis_tdata_o[8:4], m_axis_tlast_o};
      if (pending_ops.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer op=%0d host=%0d guest=%0d last=%0d", $time,
                 got.op_kind, got.host_index, got.guest_index, got.last);
      end else begin
        want = pending_ops.pop_front();
        if (got.op_kind !== want.op_kind || got.host_index !== want.host_index ||
            got.guest_index !== want.guest_index || got.last !== want.last) begin
          errors++;
          $display("%0t: expected op=%0d host=%0d guest=%0d last=%0d, actual op=%0d host=%0d guest=%0d last=%0d",
                   $time, want.op_kind, want.host_index, want.guest_index, want.last,
                   got.op_kind, got.host_index, got.guest_index, got.last);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    mask_q    = MaskReset;
    alloc_ptr = 0;
    rebuild_pool();
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_spill();
    test_random();
    test_backpressure();
    test_mask_settings();
    send_random(20);
    wait_quiet();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hdl/ghra_pkg.sv
hdl/ghra_front.sv
hdl/ghra_back.sv
hdl/guest_host_register_allocator.sv
tb/sv/tb_guest_host_register_allocator.sv
